>>> rtl/ddo_pkg.sv
// Shared constants and tables for the differential-drive odometry block.
package ddo_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_WHEEL_RADIUS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_AXLE     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_PERIOD  = 2'd2;

  // Register reset values
  localparam logic [15:0] WHEEL_RADIUS_RST = 16'd1343;
  localparam logic [15:0] INV_AXLE_RST     = 16'd4491;

  // CORDIC start value: inverse gain, Q2.30
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  // Binary-angle units per radian scaled by 2^-4 (2^27/pi)
  localparam int unsigned        TURN_W       = 26;
  localparam logic [TURN_W-1:0]  TURN_PER_RAD = 26'd42722830;

  // Arctangent of 2^-i as a binary angle, 2^32 per turn
  localparam int unsigned ATAN_W = 30;

  function automatic logic [ATAN_W-1:0] atan_bam(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/diff_drive_encoder_odometry_top.sv
// Differential-drive wheel odometry with Euler update, bit-serial datapath.
//
//  Channel | Dir | Beat contents (low bits first)
//  --------+-----+--------------------------------------------------
//  in_*    | in  | left_rot[15:0], right_rot[15:0]
//  out_*   | out | pos_x[31:0], pos_y[31:0], heading_out[31:0]
//  cfg_*   | in  | index 0 wheel radius, 1 inverse axle, 2 period
//
// A beat runs through the serial chain from acceptance to result: the 16-bit travel
// multiplies and CORDIC side by side, then the 16-bit inverse-axle multiply and the
// 26-bit angle-scale multiply for the heading, with the 32-bit cosine and sine ones.
// in_tready is high only between items; a result waiting in the output register
// lets the next beat enter, which then holds before its update until that result leaves.
// Synchronous active-low reset clears position and heading to zero, radius to 1343
// and inverse axle to 4491.
module diff_drive_encoder_odometry_top #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: left_rot[15:0], right_rot[31:16]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,
  // out_tdata: pos_x[31:0], pos_y[63:32], heading_out[95:64]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [95:0]                    out_tdata,
  input  logic                           cfg_wr_en,
  input  logic [ddo_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [15:0]                    cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN1,
    ST_RUN2,
    ST_RUN3,
    ST_UPD
  } state_t;

  localparam logic [64:0] ROUND_XY = 65'h1 << 42;

  state_t       state_r, state_nxt;
  logic [15:0]  radius_r;
  logic [15:0]  inv_axle_r;
  logic [31:0]  x_r, x_nxt;
  logic [31:0]  y_r, y_nxt;
  logic [31:0]  heading_r, heading_nxt;
  logic         out_tvalid_r, out_tvalid_nxt;
  logic [95:0]  out_tdata_r;
  logic         turn_neg_r;

  logic         in_fire;
  logic         upd_fire;
  logic         start_b;
  logic         start_c;

  logic [16:0]  lr_sum;
  logic [16:0]  rl_diff;
  logic [15:0]  rl_mag;

  logic         sum_busy, dif_busy, cor_busy, cos_busy, sin_busy, inv_busy, turn_busy;
  logic [32:0]  sum_p;
  logic [31:0]  dif_p;
  logic [31:0]  cos_v, sin_v;
  logic [64:0]  cos_p, sin_p;
  logic [47:0]  inv_p;
  logic [63:0]  turn_p;

  logic [64:0]  dx_full, dy_full;
  logic [31:0]  turn_mag;
  logic [31:0]  dh;

  // Add a signed step to a position and clamp at the 32-bit limits
  function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [21:0] d);
    logic [33:0] s;
    s = {{2{acc[31]}}, acc} + {{12{d[21]}}, d};
    if (!s[33] && (s[32:31] != 2'b00)) begin
      return 32'h7FFF_FFFF;
    end else if (s[33] && (s[32:31] != 2'b11)) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  // Configuration writes; the period cancels and is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= ddo_pkg::WHEEL_RADIUS_RST;
      inv_axle_r <= ddo_pkg::INV_AXLE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        ddo_pkg::REG_WHEEL_RADIUS: radius_r   <= cfg_wr_data;
        ddo_pkg::REG_INV_AXLE:     inv_axle_r <= cfg_wr_data;
        ddo_pkg::REG_STEP_PERIOD:  ;
        default:                   ;
      endcase
    end
  end

  // Wheel sum and difference of the incoming beat
  assign lr_sum  = {in_tdata[15], in_tdata[15:0]} + {in_tdata[31], in_tdata[31:16]};
  assign rl_diff = {in_tdata[31], in_tdata[31:16]} - {in_tdata[15], in_tdata[15:0]};
  assign rl_mag  = rl_diff[16] ? 16'(-rl_diff) : rl_diff[15:0];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign start_b   = (state_r == ST_RUN1) && !sum_busy && !dif_busy && !cor_busy;
  assign start_c   = (state_r == ST_RUN2) && !inv_busy;
  assign upd_fire  = (state_r == ST_UPD) && (!out_tvalid_r || out_tready);

  // Travel sum: (left + right) * radius
  ddo_smul #(.WA(17), .WB(16), .WP(33), .A_SIGNED(1'b1), .B_SIGNED(1'b0)) u_sum (
    .clk(clk), .rst_n(rst_n), .start(in_fire), .a(lr_sum), .b(radius_r),
    .busy(sum_busy), .p(sum_p)
  );

  // Travel difference magnitude: |right - left| * radius
  ddo_smul #(.WA(16), .WB(16), .WP(32), .A_SIGNED(1'b0), .B_SIGNED(1'b0)) u_dif (
    .clk(clk), .rst_n(rst_n), .start(in_fire), .a(rl_mag), .b(radius_r),
    .busy(dif_busy), .p(dif_p)
  );

  // Cosine and sine of the heading held before this beat
  ddo_cordic #(.STAGES(CORDIC_STAGES)) u_cor (
    .clk(clk), .rst_n(rst_n), .start(in_fire), .angle(heading_r),
    .busy(cor_busy), .cos_out(cos_v), .sin_out(sin_v)
  );

  // Position steps before rounding
  ddo_smul #(.WA(33), .WB(32), .WP(65), .A_SIGNED(1'b1), .B_SIGNED(1'b1)) u_cos (
    .clk(clk), .rst_n(rst_n), .start(start_b), .a(sum_p), .b(cos_v),
    .busy(cos_busy), .p(cos_p)
  );

  ddo_smul #(.WA(33), .WB(32), .WP(65), .A_SIGNED(1'b1), .B_SIGNED(1'b1)) u_sin (
    .clk(clk), .rst_n(rst_n), .start(start_b), .a(sum_p), .b(sin_v),
    .busy(sin_busy), .p(sin_p)
  );

  // Turn magnitude in radians, then scaled to binary-angle units
  ddo_smul #(.WA(32), .WB(16), .WP(48), .A_SIGNED(1'b0), .B_SIGNED(1'b0)) u_inv (
    .clk(clk), .rst_n(rst_n), .start(start_b), .a(dif_p), .b(inv_axle_r),
    .busy(inv_busy), .p(inv_p)
  );

  ddo_smul #(.WA(48), .WB(ddo_pkg::TURN_W), .WP(64), .A_SIGNED(1'b0), .B_SIGNED(1'b0))
    u_turn (
    .clk(clk), .rst_n(rst_n), .start(start_c), .a(inv_p), .b(ddo_pkg::TURN_PER_RAD),
    .busy(turn_busy), .p(turn_p)
  );

  // Round the steps: position half up, heading half away from zero
  assign dx_full  = cos_p + ROUND_XY;
  assign dy_full  = sin_p + ROUND_XY;
  assign turn_mag = turn_p[63:32] + {31'b0, turn_p[31]};
  assign dh       = turn_neg_r ? -turn_mag : turn_mag;

  // Sequence the phases and apply the update
  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    heading_nxt    = heading_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RUN1;
        end
      end
      ST_RUN1: begin
        if (start_b) begin
          state_nxt = ST_RUN2;
        end
      end
      ST_RUN2: begin
        if (start_c) begin
          state_nxt = ST_RUN3;
        end
      end
      ST_RUN3: begin
        if (!cos_busy && !sin_busy && !turn_busy) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_fire) begin
          x_nxt          = sat_add(x_r, dx_full[64:43]);
          y_nxt          = sat_add(y_r, dy_full[64:43]);
          heading_nxt    = heading_r + dh;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      x_r          <= '0;
      y_r          <= '0;
      heading_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      x_r          <= x_nxt;
      y_r          <= y_nxt;
      heading_r    <= heading_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Hold the turn sign and the result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      turn_neg_r <= rl_diff[16];
    end
    if (upd_fire) begin
      out_tdata_r <= {heading_nxt, y_nxt, x_nxt};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  a_accept_starts_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> cor_busy && sum_busy && dif_busy)
    else $error("accepted beat did not start the first phase");

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(sum_busy || dif_busy || cor_busy || cos_busy || sin_busy ||
                    inv_busy || turn_busy))
    else $error("serial unit busy while ready for a beat");

  a_heading_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !upd_fire |=> $stable(heading_r))
    else $error("heading changed outside the update");

  a_update_presents_result: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire |=> out_tvalid_r && (out_tdata_r[95:64] == heading_r))
    else $error("update did not load the output register");
`endif

endmodule

>>> rtl/ddo_smul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module ddo_smul #(
  parameter int unsigned WA       = 16,
  parameter int unsigned WB       = 16,
  parameter int unsigned WP       = 32,
  parameter bit          A_SIGNED = 1'b0,
  parameter bit          B_SIGNED = 1'b0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [WA-1:0] a,
  input  logic [WB-1:0] b,
  output logic          busy,
  output logic [WP-1:0] p
);

  localparam int unsigned CW = $clog2(WB);

  logic [WP-1:0] a_r;
  logic [WP-1:0] acc_r;
  logic [WP-1:0] acc_nxt;
  logic [WB-1:0] b_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          last;
  logic [WP-1:0] a_ext;

  assign last  = (cnt_r == CW'(WB - 1));
  assign a_ext = {{(WP-WA){A_SIGNED & a[WA-1]}}, a};

  // Add the shifted multiplicand; the sign bit of a signed multiplier weighs negative
  always_comb begin
    if (!b_r[0]) begin
      acc_nxt = acc_r;
    end else if (B_SIGNED && last) begin
      acc_nxt = acc_r - a_r;
    end else begin
      acc_nxt = acc_r + a_r;
    end
  end

  // Hold busy from start through the last multiplier bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && last) begin
      busy_r <= 1'b0;
    end
  end

  // Load operands, then advance one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_ext;
      b_r   <= b;
      acc_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      a_r   <= a_r << 1;
      b_r   <= b_r >> 1;
      acc_r <= acc_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign p    = acc_r;

endmodule

>>> rtl/ddo_cordic.sv
// Rotation-mode CORDIC giving cosine and sine of a binary angle, one iteration per cycle.
module ddo_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out
);

  localparam int unsigned IW = $clog2(STAGES);

  logic signed [31:0] x_r;
  logic signed [31:0] y_r;
  logic signed [31:0] z_r;
  logic signed [31:0] x_nxt;
  logic signed [31:0] y_nxt;
  logic signed [31:0] z_nxt;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [31:0] atan_s;
  logic [IW-1:0]      cnt_r;
  logic               flip_r;
  logic               busy_r;
  logic               last;
  logic               flip;

  assign last   = (cnt_r == IW'(STAGES - 1));
  // Angles in the left half-plane rotate by half a turn and negate at the end
  assign flip   = angle[31] ^ angle[30];
  assign xs     = x_r >>> cnt_r;
  assign ys     = y_r >>> cnt_r;
  assign atan_s = signed'({2'b00, ddo_pkg::atan_bam(5'(cnt_r))});

  // Rotate toward zero residual angle
  always_comb begin
    if (!z_r[31]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_s;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_s;
    end
  end

  // Hold busy from start through the last iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && last) begin
      busy_r <= 1'b0;
    end
  end

  // Load the start vector, then iterate
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= ddo_pkg::CORDIC_GAIN_Q30;
      y_r    <= '0;
      z_r    <= flip ? signed'(angle + 32'h8000_0000) : signed'(angle);
      flip_r <= flip;
      cnt_r  <= '0;
    end else if (busy_r) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign busy    = busy_r;
  assign cos_out = flip_r ? -x_r : x_r;
  assign sin_out = flip_r ? -y_r : y_r;

endmodule

>>> tb/diff_drive_encoder_odometry_top_tb.sv
// Self-checking testbench for the differential-drive odometry block.
`timescale 1ns / 1ps

module diff_drive_encoder_odometry_top_tb;

  localparam int          CORDIC_STAGES  = 16;
  localparam int          DUT_LATENCY    = ((CORDIC_STAGES > 16) ? CORDIC_STAGES : 16) + 46;
  localparam int          SETTLE_CYCLES  = 2 * DUT_LATENCY;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          LONG_HOLD      = 300;
  localparam int          PHASE_ITEMS    = 160;
  localparam int          DIR_ROWS       = 22;
  localparam longint      CORDIC_START   = 64'sd652032874;
  localparam logic [63:0] TURN_SCALE     = 64'd42722830;
  localparam logic [ddo_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  // Pose as carried on out_tdata: x in the low word
  typedef struct packed {
    logic [31:0] h;
    logic [31:0] y;
    logic [31:0] x;
  } odo_pose_t;

  typedef struct packed {
    logic [15:0] l;
    logic [15:0] r;
    logic        typed;
    odo_pose_t   val;
  } dir_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [31:0]                    in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [95:0]                    out_tdata;
  logic                           cfg_wr_en;
  logic [ddo_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [15:0]                    cfg_wr_data;

  // Predictor state and register copies
  logic [31:0] est_x;
  logic [31:0] est_y;
  logic [31:0] est_heading;
  logic [15:0] reg_radius;
  logic [15:0] reg_inv_axle;
  logic [9:0]  reg_period;

  odo_pose_t pose_q [$];
  int        mismatch_cnt = 0;
  int        stall_run = 0;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  bit        typed_on = 1'b0;
  odo_pose_t typed_pose = '0;

  longint atan_tbl [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  // Directed beats; expected pose typed in only for the trivial zero-travel rows
  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{16'h0000, 16'h0000, 1'b1, 96'h0},
    '{16'h0001, 16'h0001, 1'b1, 96'h0},
    '{16'hFFFF, 16'hFFFF, 1'b1, 96'h0},
    '{16'h7FFF, 16'h7FFF, 1'b0, 96'h0},
    '{16'h8000, 16'h8000, 1'b0, 96'h0},
    '{16'h7FFF, 16'h8000, 1'b0, 96'h0},
    '{16'h8000, 16'h7FFF, 1'b0, 96'h0},
    '{16'h7FFF, 16'h0000, 1'b0, 96'h0},
    '{16'h0000, 16'h7FFF, 1'b0, 96'h0},
    '{16'h8000, 16'h0000, 1'b0, 96'h0},
    '{16'h0000, 16'h8000, 1'b0, 96'h0},
    '{16'h0001, 16'hFFFF, 1'b0, 96'h0},
    '{16'hFFFF, 16'h0001, 1'b0, 96'h0},
    '{16'h1000, 16'h1000, 1'b0, 96'h0},
    '{16'hF000, 16'h1000, 1'b0, 96'h0},
    '{16'hF000, 16'h1000, 1'b0, 96'h0},
    '{16'h1000, 16'h1000, 1'b0, 96'h0},
    '{16'h5555, 16'hAAAA, 1'b0, 96'h0},
    '{16'hAAAA, 16'h5555, 1'b0, 96'h0},
    '{16'h2000, 16'hE000, 1'b0, 96'h0},
    '{16'h2000, 16'h2000, 1'b0, 96'h0},
    '{16'h0000, 16'h0000, 1'b0, 96'h0}
  };

  diff_drive_encoder_odometry_top #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] sat_add32(input logic [31:0] acc, input longint d);
    longint s;
    s = longint'($signed(acc)) + d;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  // Advance the odometry copy by one sample and return the new pose
  function automatic odo_pose_t predict_pose(input logic signed [15:0] l, r);
    longint      dl, dr, sum, diff, z, cx, cy, xs, ys, dx, dy, prod;
    logic [63:0] m, hi, lo, rnd;
    logic [31:0] dh;
    bit          flip;
    odo_pose_t   p;
    dl   = longint'(l) * longint'(reg_radius);
    dr   = longint'(r) * longint'(reg_radius);
    sum  = dl + dr;
    diff = dr - dl;

    // Rotate the gain vector by the old heading, folding the back half-plane
    z    = longint'($signed(est_heading));
    cx   = CORDIC_START;
    cy   = 0;
    flip = 1'b0;
    if (z >= 64'sd1073741824 || z < -64'sd1073741824) begin
      flip = 1'b1;
      z    = longint'($signed(est_heading + 32'h8000_0000));
    end
    for (int i = 0; i < CORDIC_STAGES && i < 30; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (z >= 0) begin
        cx = cx - ys;
        cy = cy + xs;
        z  = z - atan_tbl[i];
      end else begin
        cx = cx + ys;
        cy = cy - xs;
        z  = z + atan_tbl[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end

    // Mean travel: Q.28 times Q2.30, halved, down to Q16.16 with round half up
    dx    = (sum * cx + (64'sd1 << 42)) >>> 43;
    dy    = (sum * cy + (64'sd1 << 42)) >>> 43;
    est_x = sat_add32(est_x, dx);
    est_y = sat_add32(est_y, dy);

    // Turn: magnitude scaled to binary angle, rounded half away from zero
    prod = diff * longint'(reg_inv_axle);
    m    = (prod < 0) ? -prod : prod;
    hi   = m >> 16;
    lo   = m & 64'hFFFF;
    rnd  = (hi * TURN_SCALE + ((lo * TURN_SCALE + 64'h8000_0000) >> 16)) >> 16;
    dh   = rnd[31:0];
    if (prod < 0) dh = 32'd0 - dh;
    est_heading = est_heading + dh;

    p.x = est_x;
    p.y = est_y;
    p.h = est_heading;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want, got);
    $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $time);
    mismatch_cnt++;
  endtask

  // Track config, predict on input beats, check output beats, count dead cycles
  always @(posedge clk) begin : monitor
    odo_pose_t want;
    odo_pose_t got;
    bit        moved;
    moved = 1'b0;
    if (!rst_n) begin
      est_x        = '0;
      est_y        = '0;
      est_heading  = '0;
      reg_radius   = ddo_pkg::WHEEL_RADIUS_RST;
      reg_inv_axle = ddo_pkg::INV_AXLE_RST;
      reg_period   = 10'd64;
      pose_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          ddo_pkg::REG_WHEEL_RADIUS: reg_radius   = cfg_wr_data;
          ddo_pkg::REG_INV_AXLE:     reg_inv_axle = cfg_wr_data;
          ddo_pkg::REG_STEP_PERIOD:  reg_period   = cfg_wr_data[9:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got   = out_tdata;
        if (pose_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", 32'h0, got.x);
        end else begin
          want = pose_q.pop_front();
          if (got.x !== want.x) report_mismatch("pos_x", want.x, got.x);
          if (got.y !== want.y) report_mismatch("pos_y", want.y, got.y);
          if (got.h !== want.h) report_mismatch("heading_out", want.h, got.h);
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        want  = predict_pose(in_tdata[15:0], in_tdata[31:16]);
        if (typed_on) want = typed_pose;
        pose_q.push_back(want);
      end
    end
    stall_run = moved ? 0 : stall_run + 1;
  end

  initial begin
    wait (stall_run >= WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Offer one beat; entered and left at a falling edge
  task automatic send_item(input logic [15:0] l, r, input bit typed, input odo_pose_t tv);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    typed_on   = typed;
    typed_pose = tv;
    in_tvalid <= 1'b1;
    in_tdata  <= {r, l};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [ddo_pkg::CFG_ADDR_W-1:0] idx, input logic [15:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every pending pose has come back, then let the pipe settle
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] l, r;
    logic [15:0] rad, inv;
    logic [9:0]  per;
    int          kind;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_addr    <= '0;
    cfg_wr_data <= '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset register values
    for (int k = 0; k < DIR_ROWS; k++) begin
      send_item(dir_tbl[k].l, dir_tbl[k].r, dir_tbl[k].typed, dir_tbl[k].val);
    end

    // Random phases, each with its own register setting and idling mode
    for (int p = 0; p < 8; p++) begin
      wait_drain();
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  rad = 16'd1343;  inv = 16'd4491;  per = 10'd64;   end
        1: begin tx_idle_pct = 80; rx_stall_pct = 0;  rad = 16'd65535; inv = 16'd65535; per = 10'd1000; end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 80; rad = 16'd1;     inv = 16'd1;     per = 10'd1;    end
        3: begin tx_idle_pct = 34; rx_stall_pct = 34; rad = 16'd0;     inv = 16'd4491;  per = 10'd64;   end
        4: begin tx_idle_pct = 0;  rx_stall_pct = 0;  rad = 16'd1343;  inv = 16'd0;     per = 10'd500;  end
        default: begin
          tx_idle_pct  = (p == 5) ? 80 : ((p == 6) ? 0 : 34);
          rx_stall_pct = (p == 5) ? 0 : ((p == 6) ? 80 : 34);
          rad = 16'($urandom_range(1, 65535));
          inv = 16'($urandom_range(1, 65535));
          per = 10'($urandom_range(1, 1000));
        end
      endcase
      cfg_write(ddo_pkg::REG_WHEEL_RADIUS, rad);
      cfg_write(ddo_pkg::REG_INV_AXLE, inv);
      cfg_write(ddo_pkg::REG_STEP_PERIOD, {6'd0, per});
      // an out-of-range index must leave every register alone
      if (p == 2) cfg_write(REG_UNUSED, 16'($urandom));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 40) hold_req = 1'b1;
        if (p == 5 && n == 80) wait_drain();
        kind = $urandom_range(0, 3);
        case (kind)
          0: begin l = 16'($urandom); r = 16'($urandom); end
          1: begin
            l = 16'($urandom_range(0, 1023)) - 16'd512;
            r = 16'($urandom_range(0, 1023)) - 16'd512;
          end
          2: begin l = 16'($urandom); r = l; end
          default: begin l = 16'($urandom); r = 16'd0 - l; end
        endcase
        send_item(l, r, 1'b0, '0);
      end
    end

    wait_drain();
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
